/* rtl/trtd_pkg.sv */
package trtd_pkg;

  localparam int CntW     = 32;
  localparam int IdW      = 8;
  localparam int NcW      = 9;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = NcW;
  localparam int InDataW  = 136;
  localparam int OutDataW = 80;
  localparam int DivCntW  = $clog2(NcW);

  typedef enum logic [CfgIdxW-1:0] {
    CfgNodeId         = 2'd0,
    CfgNodeCount      = 2'd1,
    CfgControlChannel = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ReqReport = 1'b0,
    ReqToken  = 1'b1
  } req_type_e;

  // lowest bits first: sent_total, received_total, token counts, terminate
  typedef struct packed {
    logic [6:0]      pad;
    logic            token_terminate_in;
    logic [CntW-1:0] token_received_count;
    logic [CntW-1:0] token_sent_count;
    logic [CntW-1:0] received_total;
    logic [CntW-1:0] sent_total;
  } in_data_t;

  typedef struct packed {
    logic [4:0]      pad;
    logic            quit_now;
    logic            forward_on_control;
    logic            forward_terminate;
    logic [CntW-1:0] forward_received_count;
    logic [CntW-1:0] forward_sent_count;
    logic [IdW-1:0]  forward_dest;
  } out_data_t;

endpackage

/* rtl/token_ring_termination_detector_core.sv */
// The result word is registered: it is valid the cycle after its input word is accepted.
// One word per cycle when neither side stalls; the result register frees whenever the
// master side takes. A write to node_id or node_count starts a remainder unit for the
// next-node address; the slave side is held off while it runs.
// Reset (rst_ni low, asynchronous): node 0 holding the token, ring of one, counts cleared.
module token_ring_termination_detector_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [trtd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [trtd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sent_total, received_total, token_sent_count, token_received_count,
  // token_terminate_in, zero pad
  input  logic [trtd_pkg::InDataW-1:0]    s_axis_tdata,
  // req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // forward_dest, forward_sent_count, forward_received_count, forward_terminate,
  // forward_on_control, quit_now, zero pad
  output logic [trtd_pkg::OutDataW-1:0]   m_axis_tdata,
  // forward_valid
  output logic                            m_axis_tuser
);
  import trtd_pkg::*;

  logic [IdW-1:0]      node_id_q, node_id_d;
  logic [NcW-1:0]      node_count_q, node_count_d;
  logic                ctrl_ch_q;

  logic                div_busy_q;
  logic [DivCntW-1:0]  div_cnt_q;
  logic [NcW-1:0]      div_num_q;
  logic [NcW-1:0]      div_den_q;
  logic [NcW-1:0]      div_rem_q;
  logic [NcW:0]        div_sh;
  logic [NcW-1:0]      div_rem_d;
  logic [IdW-1:0]      dest_q;
  logic                div_start;

  logic [CntW-1:0]     held_sent_q, held_recv_q;
  logic                held_term_q;
  logic                holds_q;
  logic [CntW-1:0]     pend_sent_q, pend_recv_q;
  logic [CntW-1:0]     last_sent_q, last_recv_q;
  logic                quit_q;
  logic                started_q;

  logic                out_valid_q;
  out_data_t           out_data_q, out_data_d;
  logic                out_fwd_q, out_fwd_d;

  in_data_t            in_w;
  logic                in_acc;
  logic [CntW-1:0]     pend_sent_new, pend_recv_new;
  logic [CntW-1:0]     held_sent_new, held_recv_new;

  assign in_w          = in_data_t'(s_axis_tdata);
  assign s_axis_tready = !div_busy_q && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // configuration
  assign div_start = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CfgNodeId ||
                                  cfg_idx_e'(cfg_idx_i) == CfgNodeCount);

  always_comb begin
    node_id_d    = node_id_q;
    node_count_d = node_count_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgNodeId:    node_id_d    = cfg_data_i[IdW-1:0];
        CfgNodeCount: node_count_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= '0;
      node_count_q <= NcW'(1);
      ctrl_ch_q    <= 1'b0;
    end else begin
      node_id_q    <= node_id_d;
      node_count_q <= node_count_d;
      if (cfg_we_i && cfg_idx_e'(cfg_idx_i) == CfgControlChannel) begin
        ctrl_ch_q <= cfg_data_i[0];
      end
    end
  end

  // restoring remainder: (node_id + 1) mod node_count, one bit per cycle
  always_comb begin
    div_sh    = {div_rem_q, div_num_q[NcW-1]};
    div_rem_d = div_sh[NcW-1:0];
    if (div_sh >= {1'b0, div_den_q}) begin
      div_rem_d = NcW'(div_sh - {1'b0, div_den_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      dest_q     <= '0;
    end else if (div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + DivCntW'(1);
      if (div_cnt_q == DivCntW'(NcW - 1)) begin
        div_busy_q <= 1'b0;
        dest_q     <= div_rem_d[IdW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_num_q <= {1'b0, node_id_d} + NcW'(1);
      div_den_q <= (node_count_d == '0) ? NcW'(1) : node_count_d;
      div_rem_q <= '0;
    end else if (div_busy_q) begin
      div_num_q <= {div_num_q[NcW-2:0], 1'b0};
      div_rem_q <= div_rem_d;
    end
  end

  // token bookkeeping
  assign pend_sent_new = pend_sent_q + (in_w.sent_total - last_sent_q);
  assign pend_recv_new = pend_recv_q + (in_w.received_total - last_recv_q);
  assign held_sent_new = held_sent_q + pend_sent_new;
  assign held_recv_new = held_recv_q + pend_recv_new;

  always_comb begin
    out_data_d          = '0;
    out_fwd_d           = 1'b0;
    out_data_d.quit_now = quit_q;
    if (req_type_e'(s_axis_tuser) == ReqReport && !quit_q && holds_q) begin
      out_fwd_d                         = 1'b1;
      out_data_d.forward_dest           = dest_q;
      out_data_d.forward_sent_count     = held_sent_new;
      out_data_d.forward_received_count = held_recv_new;
      out_data_d.forward_terminate      = held_term_q;
      out_data_d.forward_on_control     = ctrl_ch_q;
      out_data_d.quit_now               = held_term_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_sent_q <= '0;
      held_recv_q <= '0;
      held_term_q <= 1'b0;
      holds_q     <= 1'b1;
      pend_sent_q <= '0;
      pend_recv_q <= '0;
      last_sent_q <= '0;
      last_recv_q <= '0;
      quit_q      <= 1'b0;
      started_q   <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_e'(cfg_idx_i) == CfgNodeId && !started_q) begin
        holds_q <= (cfg_data_i[IdW-1:0] == '0);
      end
      if (in_acc) begin
        started_q <= 1'b1;
        if (req_type_e'(s_axis_tuser) == ReqToken) begin
          held_term_q <= in_w.token_terminate_in ||
                         (held_sent_q == in_w.token_sent_count &&
                          held_recv_q == in_w.token_received_count &&
                          in_w.token_sent_count == in_w.token_received_count);
          held_sent_q <= in_w.token_sent_count;
          held_recv_q <= in_w.token_received_count;
          holds_q     <= 1'b1;
        end else if (!quit_q) begin
          last_sent_q <= in_w.sent_total;
          last_recv_q <= in_w.received_total;
          if (holds_q) begin
            held_sent_q <= held_sent_new;
            held_recv_q <= held_recv_new;
            pend_sent_q <= '0;
            pend_recv_q <= '0;
            quit_q      <= held_term_q;
            holds_q     <= 1'b0;
          end else begin
            pend_sent_q <= pend_sent_new;
            pend_recv_q <= pend_recv_new;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
      out_fwd_q  <= out_fwd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);
  assign m_axis_tuser  = out_fwd_q;

  a_no_fwd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OutDataW-7:0] == '0)
    else $error("non-forward word carries forward fields");

  a_quit_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quit_q |=> quit_q)
    else $error("quit dropped");

  a_div_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> !s_axis_tready)
    else $error("word accepted while next-node address is being computed");

  a_fwd_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && out_fwd_d |=> !holds_q && m_axis_tuser)
    else $error("forward did not release the token");

endmodule

/* dv/tb_token_ring_termination_detector_core.sv */
`timescale 1ns / 100ps

module tb_token_ring_termination_detector_core;
  import trtd_pkg::*;

  localparam int                 WatchdogLimit = 4000;
  localparam int                 HoldOffCycles = 300;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare   = 2'd3;

  typedef struct packed {
    logic      fwd;
    out_data_t data;
  } result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  // node state as the ring protocol defines it
  logic [IdW-1:0]  ring_id      = '0;
  logic [NcW-1:0]  ring_count   = 9'd1;
  logic            ring_ctl     = 1'b0;
  logic [CntW-1:0] tok_sent     = '0;
  logic [CntW-1:0] tok_recv     = '0;
  logic            tok_term     = 1'b0;
  logic            tok_held     = 1'b1;
  logic [CntW-1:0] pend_sent    = '0;
  logic [CntW-1:0] pend_recv    = '0;
  logic [CntW-1:0] last_sent    = '0;
  logic [CntW-1:0] last_recv    = '0;
  logic            quit_seen    = 1'b0;
  logic            node_started = 1'b0;

  result_t expected_words[$];
  int      mismatches    = 0;
  int      quiet_cycles  = 0;
  bit      idling_on     = 1'b1;
  bit      stall_request = 1'b0;

  token_ring_termination_detector_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always #4 clk_i = ~clk_i;

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      CfgNodeId: begin
        ring_id = val[IdW-1:0];
        if (!node_started) tok_held = (val[IdW-1:0] == '0);
      end
      CfgNodeCount: ring_count = val;
      CfgControlChannel: ring_ctl = val[0];
      default: ;
    endcase
  endtask

  task automatic predict_token_step(input req_type_e req, input in_data_t w,
                                    output result_t r);
    int ring;
    r = '0;
    node_started = 1'b1;
    if (req == ReqToken) begin
      if (!w.token_terminate_in && tok_sent == w.token_sent_count &&
          tok_recv == w.token_received_count &&
          w.token_sent_count == w.token_received_count) begin
        tok_term = 1'b1;
      end else begin
        tok_term = w.token_terminate_in;
      end
      tok_sent = w.token_sent_count;
      tok_recv = w.token_received_count;
      tok_held = 1'b1;
      r.data.quit_now = quit_seen;
    end else if (quit_seen) begin
      r.data.quit_now = 1'b1;
    end else begin
      pend_sent = pend_sent + (w.sent_total - last_sent);
      last_sent = w.sent_total;
      pend_recv = pend_recv + (w.received_total - last_recv);
      last_recv = w.received_total;
      if (tok_held) begin
        ring = (ring_count == '0) ? 1 : int'(ring_count);
        tok_sent = tok_sent + pend_sent;
        tok_recv = tok_recv + pend_recv;
        pend_sent = '0;
        pend_recv = '0;
        if (tok_term) quit_seen = 1'b1;
        tok_held = 1'b0;
        r.fwd = 1'b1;
        r.data.forward_dest = IdW'(((int'(ring_id) + 1) % ring) % 256);
        r.data.forward_sent_count = tok_sent;
        r.data.forward_received_count = tok_recv;
        r.data.forward_terminate = tok_term;
        r.data.forward_on_control = ring_ctl;
      end
      r.data.quit_now = quit_seen;
    end
  endtask

  function automatic in_data_t report_word(input logic [CntW-1:0] s, input logic [CntW-1:0] r);
    in_data_t w;
    w = '0;
    w.sent_total = s;
    w.received_total = r;
    w.token_sent_count = $urandom;
    w.token_received_count = $urandom;
    w.token_terminate_in = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic in_data_t token_word(input logic [CntW-1:0] s, input logic [CntW-1:0] r,
                                          input logic term);
    in_data_t w;
    w = '0;
    w.sent_total = $urandom;
    w.received_total = $urandom;
    w.token_sent_count = s;
    w.token_received_count = r;
    w.token_terminate_in = term;
    return w;
  endfunction

  task automatic send_word(input req_type_e req, input in_data_t w);
    result_t r;
    while (idling_on && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_token_step(req, w, r);
    expected_words = {expected_words, r};
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [IdW-1:0] id, input logic [NcW-1:0] count,
                            input logic ctl);
    wait_idle();
    write_reg(CfgNodeId, {1'($urandom), id});
    write_reg(CfgNodeCount, count);
    write_reg(CfgControlChannel, {8'($urandom), ctl});
    write_reg(CfgIdxSpare, CfgDataW'($urandom));
    end_writes();
  endtask

  task automatic next_random_word(output req_type_e req, output in_data_t w);
    int pick;
    pick = $urandom_range(99);
    w = token_word($urandom, $urandom, 1'b0);
    if (tok_term) begin
      // clear a pending terminate so the ring keeps running
      req = ReqToken;
      w.token_received_count = w.token_sent_count + $urandom_range(1, 1000);
    end else if (pick < 45) begin
      req = ReqToken;
      if (pick < 10) begin
        w.token_sent_count = tok_sent;
        w.token_received_count = tok_recv;
      end else if (pick < 20) begin
        w.token_received_count = w.token_sent_count;
      end else if (pick < 26) begin
        w.token_terminate_in = 1'b1;
      end
    end else begin
      req = ReqReport;
      w.token_terminate_in = 1'($urandom_range(1));
      if (pick < 80) begin
        w.sent_total = last_sent + $urandom_range(0, 50);
        w.received_total = last_recv + $urandom_range(0, 50);
      end else if (pick < 87) begin
        w.sent_total = last_sent;
        w.received_total = last_recv;
      end
    end
  endtask

  task automatic run_random(input int n_items);
    req_type_e req;
    in_data_t  w;
    repeat (n_items) begin
      next_random_word(req, w);
      send_word(req, w);
    end
  endtask

  task automatic test_config_before_start();
    write_reg(CfgNodeId, 9'd9);
    write_reg(CfgNodeId, 9'd0);
    write_reg(CfgNodeId, 9'd7);
    write_reg(CfgNodeCount, 9'd0);
    write_reg(CfgControlChannel, 9'h1FF);
    write_reg(CfgIdxSpare, 9'h155);
    end_writes();
    send_word(ReqReport, report_word(32'h0, 32'h0));
    send_word(ReqReport, report_word(32'hFFFF_FFFF, 32'h1));
    send_word(ReqToken, token_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_word(ReqReport, report_word(32'h5, 32'h0));
    send_word(ReqReport, report_word(32'h0, 32'hFFFF_FFFF));
    send_word(ReqToken, token_word(32'h0, 32'h0, 1'b1));
    send_word(ReqToken, token_word(32'h0, 32'hFFFF_FFFF, 1'b0));
    send_word(ReqReport, report_word(32'h8000_0000, 32'h7FFF_FFFF));
  endtask

  task automatic test_ring_wrap();
    logic [IdW-1:0] ids[6]    = '{8'd0, 8'd255, 8'd255, 8'd3, 8'd254, 8'd200};
    logic [NcW-1:0] counts[6] = '{9'd1, 9'd256, 9'd511, 9'd9, 9'd255, 9'd300};
    for (int k = 0; k < 6; k++) begin
      set_config(ids[k], counts[k], k[0]);
      send_word(ReqReport, report_word($urandom, $urandom));
      send_word(ReqToken, token_word($urandom, 32'h1234_5678 + k, 1'b0));
      send_word(ReqReport, report_word($urandom, $urandom));
    end
  endtask

  task automatic test_random_ring(input logic [IdW-1:0] id, input logic [NcW-1:0] count,
                                  input logic ctl, input bit idle, input int n_items);
    set_config(id, count, ctl);
    idling_on = idle;
    run_random(n_items);
    idling_on = 1'b1;
  endtask

  task automatic test_output_holdoff();
    set_config(8'($urandom), 9'($urandom_range(1, 256)), 1'($urandom));
    stall_request = 1'b1;
    run_random(80);
  endtask

  task automatic test_termination();
    logic [CntW-1:0] v;
    v = $urandom;
    set_config(8'd4, 9'd5, 1'b1);
    send_word(ReqToken, token_word(v, v, 1'b0));
    send_word(ReqToken, token_word(v, v, 1'b0));
    send_word(ReqReport, report_word(last_sent, last_recv));
    send_word(ReqReport, report_word($urandom, $urandom));
    send_word(ReqToken, token_word($urandom, $urandom, 1'b1));
    send_word(ReqReport, report_word($urandom, $urandom));
  endtask

  task automatic check_field(input string field, input logic [CntW-1:0] got,
                             input logic [CntW-1:0] want);
    if (got !== want) begin
      $display("mismatch %s: got %0h expected %0h", field, got, want);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_result
    result_t   want;
    out_data_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_words.size() == 0) begin
        check_field("unexpected word", 1, 0);
      end else begin
        want = expected_words.pop_front();
        check_field("forward_valid", CntW'(m_axis_tuser), CntW'(want.fwd));
        check_field("forward_dest", CntW'(got.forward_dest),
                    CntW'(want.data.forward_dest));
        check_field("forward_sent_count", got.forward_sent_count,
                    want.data.forward_sent_count);
        check_field("forward_received_count", got.forward_received_count,
                    want.data.forward_received_count);
        check_field("forward_terminate", CntW'(got.forward_terminate),
                    CntW'(want.data.forward_terminate));
        check_field("forward_on_control", CntW'(got.forward_on_control),
                    CntW'(want.data.forward_on_control));
        check_field("quit_now", CntW'(got.quit_now), CntW'(want.data.quit_now));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("** token_ring_termination_detector_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      m_axis_tready <= !(idling_on && $urandom_range(99) < 34);
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_config_before_start();
    test_ring_wrap();
    test_random_ring(8'd0, 9'd1, 1'b0, 1'b1, 130);
    test_random_ring(8'd255, 9'd256, 1'b1, 1'b0, 130);
    test_output_holdoff();
    test_random_ring(8'($urandom), 9'd0, 1'b0, 1'b1, 100);
    test_random_ring(8'($urandom), 9'd511, 1'b1, 1'b1, 100);
    test_random_ring(8'($urandom), 9'($urandom_range(2, 256)), 1'($urandom), 1'b1, 110);
    test_termination();
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (expected_words.size() != 0) check_field("words left over", expected_words.size(), 0);
    if (mismatches == 0) begin
      $display("** token_ring_termination_detector_core: PASSED **");
    end else begin
      $display("** token_ring_termination_detector_core: FAILED **");
    end
    $finish;
  end

endmodule
